// ===== hdl/ucbidx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbidx_pkg
// Shared widths, constants, types and helpers of the UCB index update block.
// ----------------------------------------------------------------------------
package ucbidx_pkg;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int COUNT_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SUM_W       = COUNT_WIDTH + 2;
    localparam int OUT_W       = 19;
    localparam int K_W         = 3;
    localparam int MASK_W      = 4;
    localparam int POP_W       = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    // log2 / ln fixed point
    localparam int Q28     = 28;
    localparam int M_W     = Q28 + 1;
    localparam int E_W     = $clog2(COUNT_WIDTH);
    localparam int LN_W    = E_W + Q28;
    localparam int SQC_W   = $clog2(Q28 + 1);
    localparam int NUM_W   = E_W + 2 * FRAC_BITS;
    localparam int NUM_LSH = (2 * FRAC_BITS >= Q28) ? 2 * FRAC_BITS - Q28 : 0;
    localparam int NUM_RSH = (2 * FRAC_BITS < Q28) ? Q28 - 2 * FRAC_BITS : 0;

    // shared serial divider and square root
    localparam int DIVD_W = max_int(max_int(NUM_W, COUNT_WIDTH + FRAC_BITS), LN_W);
    localparam int DCNT_W = $clog2(DIVD_W + 1);
    localparam int SQ_W   = (DIVD_W + 1) / 2;
    localparam int RCNT_W = $clog2(SQ_W + 1);

    localparam logic [Q28-1:0]         LN2_Q28   = Q28'(186065279);
    localparam logic [OUT_W-1:0]       OUT_MAX   = '1;
    localparam logic [SUM_W-1:0]       SUM_RST   = SUM_W'(4);
    localparam logic [COUNT_WIDTH-1:0] TRIAL_RST = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] ROUND_RST = COUNT_WIDTH'(11);
    localparam logic [K_W-1:0]         K_RST     = K_W'(2);

    localparam logic REQ_INIT   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_NORM,
        LOG_SQUARE,
        LOG_SCALE
    } log_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_MEAN,
        ST_LOGW,
        ST_RATIO,
        ST_ROOT,
        ST_OUT
    } top_state_t;

endpackage

// ===== hdl/ucbidx_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbidx_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ucbidx_div import ucbidx_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [DIVD_W-1:0]      dividend,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output unit_stat_t             stat,
    output logic [DIVD_W-1:0]      quotient
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [DCNT_W-1:0]      cnt_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [DIVD_W-1:0]      quo_reg;
    logic [COUNT_WIDTH-1:0] dvs_reg;
    logic [COUNT_WIDTH:0]   shifted;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;

    // dividend bits leave at the top of quo_reg while quotient bits enter below
    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIVD_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== hdl/ucbidx_log.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbidx_log
// Natural log in Q28: leading-one search one bit a cycle, then one squaring
// per fraction bit, then a scale by ln 2.
// ----------------------------------------------------------------------------
module ucbidx_log import ucbidx_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] value,
    output unit_stat_t             stat,
    output logic [LN_W-1:0]        ln_q28
);

    log_state_t                   state_reg;
    log_state_t                   state_next;
    logic                         done_reg;
    logic [COUNT_WIDTH-1:0]       norm_reg;
    logic [E_W-1:0]               exp_reg;
    logic [M_W-1:0]               mant_reg;
    logic [Q28-1:0]               frac_reg;
    logic [SQC_W-1:0]             cnt_reg;
    logic [LN_W-1:0]              ln_reg;
    logic [COUNT_WIDTH+M_W-1:0]   norm_ext;
    logic [2*M_W-1:0]             square;
    logic [M_W:0]                 sq_top;
    logic [LN_W+Q28-1:0]          scaled;
    logic                         small_in;

    assign small_in = (value[COUNT_WIDTH-1:1] == '0);
    assign norm_ext = {norm_reg, {M_W{1'b0}}};
    assign square   = mant_reg * mant_reg;
    assign sq_top   = square[Q28+M_W:Q28];
    assign scaled   = {exp_reg, frac_reg} * LN2_Q28;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LOG_IDLE: begin
                if (start && !small_in) begin
                    state_next = LOG_NORM;
                end
            end
            LOG_NORM: begin
                if (norm_reg[COUNT_WIDTH-1]) begin
                    state_next = LOG_SQUARE;
                end
            end
            LOG_SQUARE: begin
                if (cnt_reg == SQC_W'(Q28 - 1)) begin
                    state_next = LOG_SCALE;
                end
            end
            LOG_SCALE: state_next = LOG_IDLE;
            default:   state_next = LOG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LOG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            case (state_reg)
                LOG_IDLE: begin
                    if (start) begin
                        norm_reg <= value;
                        exp_reg  <= E_W'(COUNT_WIDTH - 1);
                        // ln of zero or one is taken as zero
                        if (small_in) begin
                            ln_reg   <= '0;
                            done_reg <= 1'b1;
                        end
                    end
                end
                LOG_NORM: begin
                    if (norm_reg[COUNT_WIDTH-1]) begin
                        mant_reg <= norm_ext[COUNT_WIDTH+M_W-1 -: M_W];
                        frac_reg <= '0;
                        cnt_reg  <= '0;
                    end else begin
                        norm_reg <= {norm_reg[COUNT_WIDTH-2:0], 1'b0};
                        exp_reg  <= exp_reg - 1'b1;
                    end
                end
                LOG_SQUARE: begin
                    // a square of two or more gives a one bit and is halved
                    if (sq_top[M_W]) begin
                        mant_reg <= sq_top[M_W:1];
                        frac_reg <= {frac_reg[Q28-2:0], 1'b1};
                    end else begin
                        mant_reg <= sq_top[M_W-1:0];
                        frac_reg <= {frac_reg[Q28-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                LOG_SCALE: begin
                    ln_reg   <= scaled[LN_W+Q28-1:Q28];
                    done_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign stat.busy = (state_reg != LOG_IDLE);
    assign stat.done = done_reg;
    assign ln_q28    = ln_reg;

endmodule

// ===== hdl/ucbidx_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbidx_sqrt
// Integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module ucbidx_sqrt import ucbidx_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] value,
    output unit_stat_t        stat,
    output logic [SQ_W-1:0]   root
);

    logic                busy_reg;
    logic                done_reg;
    logic [RCNT_W-1:0]   cnt_reg;
    logic [2*SQ_W-1:0]   val_reg;
    logic [SQ_W+1:0]     rem_reg;
    logic [SQ_W-1:0]     root_reg;
    logic [SQ_W+3:0]     rem_sh;
    logic [SQ_W+3:0]     test;
    logic [SQ_W+3:0]     diff;
    logic                fits;

    assign rem_sh = {rem_reg, val_reg[2*SQ_W-1 -: 2]};
    assign test   = (SQ_W + 4)'({root_reg, 2'b01});
    assign diff   = rem_sh - test;
    assign fits   = rem_sh >= test;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= RCNT_W'(SQ_W);
                val_reg  <= (2 * SQ_W)'(value);
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[SQ_W+1:0] : rem_sh[SQ_W+1:0];
                root_reg <= {root_reg[SQ_W-2:0], fits};
                val_reg  <= {val_reg[2*SQ_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == RCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ===== hdl/ucb_bandit_index_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb_bandit_index_update
// One-arm UCB1 index: keeps reward sum, trials and rounds, returns
// sum/trials + sqrt(ln(rounds)/trials) in unsigned Q3.16 per item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata observation, s_tuser req_type
//  m_        out  m_tvalid/m_tready    m_tdata ucb_index
//  cfg_      in   cfg_valid/cfg_ready  cfg_data occupancy_limit
//
// One item at a time, sequenced through the serial divider (mean, then
// ln/trials) and the serial square root; the log unit runs alongside the first
// division, and the second division waits until the log unit is done.
// Reset (aresetn low, synchronous) restores sum 1.0, trials 1, rounds 11, K 2.
// A result waiting on m_tready holds the next item at its final load; no input
// is taken meanwhile.
// ----------------------------------------------------------------------------
module ucb_bandit_index_update import ucbidx_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [3:0] chosen_set, [4] within_limit, [8:5] channel_status,
    // [12:9] vacant_mask, [16:13] target_mask, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [18:0] ucb_index, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [K_W-1:0]       cfg_data
);

    function automatic logic [POP_W-1:0] pop4(input logic [MASK_W-1:0] v);
        return POP_W'(v[0]) + POP_W'(v[1]) + POP_W'(v[2]) + POP_W'(v[3]);
    endfunction

    top_state_t             state_reg;
    top_state_t             state_next;
    logic [K_W-1:0]         k_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [COUNT_WIDTH-1:0] trial_reg;
    logic [COUNT_WIDTH-1:0] round_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [COUNT_WIDTH-1:0] trial_next;
    logic [COUNT_WIDTH-1:0] round_next;
    logic [DIVD_W-1:0]      mean_reg;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       index_reg;

    logic [MASK_W-1:0] chosen, status, vacant, target, g, rm;
    logic              within_lim, s_accept;
    logic [POP_W-1:0]  c, vg, og, orr, vr, reward;
    logic              trial;
    logic [SUM_W:0]    sum_add;

    logic                   div_start, log_start, sqrt_start, out_load;
    logic [DIVD_W-1:0]      div_dividend;
    logic [COUNT_WIDTH-1:0] divisor;
    logic [DIVD_W-1:0]      quotient;
    logic [LN_W-1:0]        ln_q28;
    logic [DIVD_W-1:0]      num;
    logic [SQ_W-1:0]        root;
    logic [DIVD_W:0]        total;
    unit_stat_t             div_stat, log_stat, sqrt_stat;

    assign chosen     = s_tdata[3:0];
    assign within_lim = s_tdata[4];
    assign status     = s_tdata[8:5];
    assign vacant     = s_tdata[12:9];
    assign target     = s_tdata[16:13];
    assign s_accept   = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);

    // trial and reward decision
    always_comb begin
        g      = chosen & target;
        rm     = chosen & ~g;
        c      = pop4(g);
        vg     = pop4(g & vacant);
        og     = c - vg;
        orr    = pop4(rm & status);
        vr     = pop4(rm) - orr;
        reward = '0;
        trial  = 1'b0;
        if (c != '0) begin
            if (within_lim) begin
                trial = 1'b1;
                if ((orr + og) <= k_reg) begin
                    reward = vr + vg;
                end
            end else if (chosen == target) begin
                trial = 1'b1;
            end else if (pop4(chosen) == k_reg) begin
                trial = 1'b0;
            end else begin
                trial = pop4(chosen & status) > k_reg;
            end
        end
    end

    always_comb begin
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(reward);
        if (s_tuser[0] == REQ_INIT) begin
            sum_next   = SUM_RST;
            trial_next = TRIAL_RST;
            round_next = ROUND_RST;
        end else begin
            round_next = (&round_reg) ? round_reg : round_reg + 1'b1;
            trial_next = trial_reg;
            sum_next   = sum_reg;
            if (trial) begin
                trial_next = (&trial_reg) ? trial_reg : trial_reg + 1'b1;
                sum_next   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            end
        end
    end

    // sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_MEAN;
            ST_MEAN:   if (div_stat.done) state_next = ST_LOGW;
            ST_LOGW:   if (!log_stat.busy) state_next = ST_RATIO;
            ST_RATIO:  if (div_stat.done) state_next = ST_ROOT;
            ST_ROOT:   if (sqrt_stat.done) state_next = ST_OUT;
            ST_OUT:    if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        log_start    = 1'b0;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        div_dividend = DIVD_W'(sum_reg) << (FRAC_BITS - 2);
        case (state_reg)
            ST_LAUNCH: begin
                div_start = 1'b1;
                log_start = 1'b1;
            end
            ST_LOGW: begin
                div_dividend = num;
                div_start    = !log_stat.busy;
            end
            ST_RATIO: sqrt_start = div_stat.done;
            ST_OUT:   out_load   = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign divisor = (trial_reg == '0) ? COUNT_WIDTH'(1) : trial_reg;
    assign num     = (DIVD_W'(ln_q28) << NUM_LSH) >> NUM_RSH;
    assign total   = (DIVD_W + 1)'(mean_reg) + (DIVD_W + 1)'(root);

    ucbidx_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    ucbidx_log u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .value   (round_reg),
        .stat    (log_stat),
        .ln_q28  (ln_q28)
    );

    ucbidx_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (quotient),
        .stat    (sqrt_stat),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= K_RST;
            sum_reg      <= SUM_RST;
            trial_reg    <= TRIAL_RST;
            round_reg    <= ROUND_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                k_reg <= cfg_data;
            end
            if (s_accept) begin
                sum_reg   <= sum_next;
                trial_reg <= trial_next;
                round_reg <= round_next;
            end
            if (state_reg == ST_MEAN && div_stat.done) begin
                mean_reg <= quotient;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                index_reg    <= (total > (DIVD_W + 1)'(OUT_MAX)) ? OUT_MAX : total[OUT_W-1:0];
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_TDATA_W'(index_reg);

endmodule
